>>> rtl/array_binary_tree_query_defines.svh
// assertion macros for the tree query block
`ifndef ARRAY_BINARY_TREE_QUERY_DEFINES_SVH
`define ARRAY_BINARY_TREE_QUERY_DEFINES_SVH

`ifndef SYNTHESIS
`define ABTQ_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ABTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ABTQ_ASSERT(lbl, ante, cons)
`define ABTQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/abtq_pkg.sv
package abtq_pkg;

  localparam int TREE_SLOTS = 128;
  localparam int VALUE_BITS = 16;

  localparam int SLOT_BITS = $clog2(TREE_SLOTS);
  localparam int CNT_BITS  = $clog2(TREE_SLOTS + 1);
  localparam int LA_W      = SLOT_BITS + 2;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 16;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ORPHAN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  localparam logic [CNT_BITS-1:0]  FULL_CNT  = CNT_BITS'(TREE_SLOTS);
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(TREE_SLOTS - 1);

  // relation lookups after the scan
  localparam int LK_W     = 3;
  localparam int LK_COUNT = 5;
  localparam logic [LK_W-1:0] LK_PARENT = 3'd0;
  localparam logic [LK_W-1:0] LK_LCHILD = 3'd1;
  localparam logic [LK_W-1:0] LK_RCHILD = 3'd2;
  localparam logic [LK_W-1:0] LK_LSIB   = 3'd3;
  localparam logic [LK_W-1:0] LK_RSIB   = 3'd4;

  typedef struct packed {
    logic                  start;
    logic                  valid;
    logic [SLOT_BITS-1:0]  idx;
    logic                  live;
    logic [VALUE_BITS-1:0] data;
  } scan_t;

  typedef struct packed {
    logic                 root_ok;
    logic                 got_child;
    logic [SLOT_BITS-1:0] child_idx;
    logic                 got_par;
    logic [SLOT_BITS-1:0] par_idx;
    logic                 got_ls;
    logic [SLOT_BITS-1:0] ls_idx;
    logic                 got_rs;
    logic [SLOT_BITS-1:0] rs_idx;
  } match_t;

endpackage

>>> rtl/abtq_in_if.sv
interface abtq_in_if import abtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FIELD_W-1:0] node_value;

  modport source (output valid, output mode, output node_value, input ready);
  modport sink (input valid, input mode, input node_value, output ready);
endinterface

>>> rtl/abtq_out_if.sv
interface abtq_out_if import abtq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  parent_value;
  logic [FIELD_W-1:0]  left_child_value;
  logic [FIELD_W-1:0]  right_child_value;
  logic [FIELD_W-1:0]  left_sibling_value;
  logic [FIELD_W-1:0]  right_sibling_value;

  modport source (
    output valid, output status, output parent_value, output left_child_value,
    output right_child_value, output left_sibling_value, output right_sibling_value,
    input ready
  );
  modport sink (
    input valid, input status, input parent_value, input left_child_value,
    input right_child_value, input left_sibling_value, input right_sibling_value,
    output ready
  );
endinterface

>>> rtl/abtq_ram.sv
module abtq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/abtq_match.sv
module abtq_match import abtq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scan_t                 scan_i,
  input  logic [VALUE_BITS-1:0] key_i,
  output match_t                match_o
);

  match_t m_q;
  logic   hit;

  // slots at or past the fill count are empty
  assign hit = ((scan_i.live ? scan_i.data : '0) == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0;
    end else if (scan_i.start) begin
      m_q <= '0;
    end else if (scan_i.valid) begin
      if (scan_i.idx == '0) begin
        m_q.root_ok <= scan_i.live && (scan_i.data != '0);
      end
      if (hit && !m_q.got_child) begin
        m_q.got_child <= 1'b1;
        m_q.child_idx <= scan_i.idx;
      end
      if (hit && (scan_i.idx != '0) && !m_q.got_par) begin
        m_q.got_par <= 1'b1;
        m_q.par_idx <= scan_i.idx;
      end
      if (hit && (scan_i.idx != '0) && !scan_i.idx[0] && !m_q.got_ls) begin
        m_q.got_ls <= 1'b1;
        m_q.ls_idx <= scan_i.idx;
      end
      if (hit && scan_i.idx[0] && !m_q.got_rs) begin
        m_q.got_rs <= 1'b1;
        m_q.rs_idx <= scan_i.idx;
      end
    end
  end

  assign match_o = m_q;

endmodule

>>> rtl/array_binary_tree_query.sv
// path to result valid: clear and most loads go straight to S_DONE; a load that reads
// its parent goes via S_LOAD, a query via S_SCAN over every slot, S_LOOK and S_DRAIN
// throughput: one item at a time, next input transfer in the cycle after the result
// is registered; a query is set by the slot-by-slot scan of the single-read-port store
// reset: control and fill count cleared; the store itself is not swept, slots at or
// past the fill count read as empty
`include "array_binary_tree_query_defines.svh"

module array_binary_tree_query import abtq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  abtq_in_if.sink    in_i,
  abtq_out_if.source out_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_LOOK  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_BITS-1:0]   fill_q, fill_d;
  logic [SLOT_BITS-1:0]  rd_idx_q, rd_idx_d;
  logic [LK_W-1:0]       lk_q, lk_d;
  logic [LK_W-1:0]       lk_cap_q;
  logic                  lv_q, lv_d;
  logic                  lok_q, lok_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] key_q;
  logic [FIELD_W-1:0]    res_q [LK_COUNT];
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  status_we;

  logic                  in_xfer;
  logic                  out_load;
  logic                  mem_we;
  logic [SLOT_BITS-1:0]  mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [SLOT_BITS-1:0]  mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;
  logic [VALUE_BITS-1:0] in_val;
  logic [SLOT_BITS-1:0]  load_par;
  logic [LA_W-1:0]       la;
  logic                  lgot;

  scan_t  scan;
  match_t mt;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign in_val     = VALUE_BITS'(in_i.node_value);
  assign load_par   = SLOT_BITS'((fill_q - CNT_BITS'(1)) >> 1);

  abtq_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(TREE_SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign scan.start = in_xfer && (in_i.mode == MODE_QUERY);
  assign scan.valid = (state_q == S_SCAN);
  assign scan.idx   = rd_idx_q;
  assign scan.live  = CNT_BITS'(rd_idx_q) < fill_q;
  assign scan.data  = mem_rdata;

  abtq_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scan_i  (scan),
    .key_i   (key_q),
    .match_o (mt)
  );

  // relation slot address for the current lookup
  always_comb begin
    la   = '0;
    lgot = 1'b0;
    case (lk_q)
      LK_PARENT: begin
        la   = LA_W'(mt.par_idx - SLOT_BITS'(1)) >> 1;
        lgot = mt.got_par;
      end
      LK_LCHILD: begin
        la   = LA_W'({mt.child_idx, 1'b1});
        lgot = mt.got_child;
      end
      LK_RCHILD: begin
        la   = LA_W'({mt.child_idx, 1'b0}) + LA_W'(2);
        lgot = mt.got_child;
      end
      LK_LSIB: begin
        la   = LA_W'(mt.ls_idx - SLOT_BITS'(1));
        lgot = mt.got_ls;
      end
      LK_RSIB: begin
        la   = LA_W'(mt.rs_idx) + LA_W'(1);
        lgot = mt.got_rs;
      end
      default: begin
        la   = '0;
        lgot = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    lk_d        = lk_q;
    lv_d        = 1'b0;
    lok_d       = 1'b0;
    status_d    = STATUS_OK;
    status_we   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = fill_q[SLOT_BITS-1:0];
    mem_wdata   = key_q;
    mem_raddr   = '0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DONE;
          case (in_i.mode)
            MODE_CLEAR: begin
              fill_d = '0;
            end
            MODE_LOAD: begin
              if (fill_q == FULL_CNT) begin
                status_d  = STATUS_FULL;
                status_we = 1'b1;
              end else if ((fill_q == '0) || (in_val == '0)) begin
                mem_we    = 1'b1;
                mem_wdata = in_val;
                fill_d    = fill_q + CNT_BITS'(1);
              end else begin
                mem_raddr = load_par;
                state_d   = S_LOAD;
              end
            end
            MODE_QUERY: begin
              mem_raddr = '0;
              rd_idx_d  = '0;
              state_d   = S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_LOAD: begin
        mem_we    = 1'b1;
        fill_d    = fill_q + CNT_BITS'(1);
        status_d  = (mem_rdata == '0) ? STATUS_ORPHAN : STATUS_OK;
        status_we = 1'b1;
        state_d   = S_DONE;
      end
      S_SCAN: begin
        mem_raddr = rd_idx_q + SLOT_BITS'(1);
        rd_idx_d  = rd_idx_q + SLOT_BITS'(1);
        if (rd_idx_q == SLOT_LAST) begin
          lk_d    = LK_PARENT;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        mem_raddr = la[SLOT_BITS-1:0];
        lv_d      = 1'b1;
        lok_d     = lgot && mt.root_ok && (la < LA_W'(fill_q));
        lk_d      = lk_q + LK_W'(1);
        if (lk_q == LK_RSIB) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      lk_q        <= '0;
      lv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      lk_q        <= lk_d;
      lv_q        <= lv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lok_q    <= lok_d;
    lk_cap_q <= lk_q;
    if (in_xfer) begin
      key_q    <= in_val;
      status_q <= status_d;
      for (int k = 0; k < LK_COUNT; k++) begin
        res_q[k] <= '0;
      end
    end else begin
      if (status_we) begin
        status_q <= status_d;
      end
      if (lv_q) begin
        res_q[lk_cap_q] <= lok_q ? FIELD_W'(mem_rdata) : '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.status              <= status_q;
      out_o.parent_value        <= res_q[LK_PARENT];
      out_o.left_child_value    <= res_q[LK_LCHILD];
      out_o.right_child_value   <= res_q[LK_RCHILD];
      out_o.left_sibling_value  <= res_q[LK_LSIB];
      out_o.right_sibling_value <= res_q[LK_RSIB];
    end
  end

  assign out_o.valid = out_valid_q;

  `ABTQ_ASSERT(a_fill_range, 1'b1, fill_q <= FULL_CNT)
  `ABTQ_ASSERT(a_no_write_busy, state_q != S_IDLE && state_q != S_LOAD, !mem_we)
  `ABTQ_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_q != S_IDLE)
  `ABTQ_ASSERT_NEXT(a_full_holds, in_xfer && in_i.mode == MODE_LOAD && fill_q == FULL_CNT, fill_q == FULL_CNT)

endmodule

>>> tb/tb_array_binary_tree_query.sv
module tb_array_binary_tree_query import abtq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned ITEM_GOAL = 1150;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] value;
    bit                 drain_first;
  } tree_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  parent;
    logic [FIELD_W-1:0]  lchild;
    logic [FIELD_W-1:0]  rchild;
    logic [FIELD_W-1:0]  lsib;
    logic [FIELD_W-1:0]  rsib;
  } tree_answer_t;

  logic clk_i;
  logic rst_ni;

  abtq_in_if  in_bus ();
  abtq_out_if out_bus ();

  array_binary_tree_query i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  tree_op_t     op_queue[$];
  tree_answer_t answer_queue[$];
  int unsigned  op_total = 0;
  int unsigned  accepted_ops = 0;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;

  // predictor state
  logic [VALUE_BITS-1:0] tree_mirror [TREE_SLOTS] = '{default: '0};
  int unsigned           mirror_fill = 0;

  // generator shadow, used only to shape stimulus
  logic [FIELD_W-1:0] plan_store [TREE_SLOTS] = '{default: '0};
  int unsigned        plan_fill = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [FIELD_W-1:0] mirror_at(int unsigned slot);
    if (slot < TREE_SLOTS) return FIELD_W'(tree_mirror[slot]);
    return '0;
  endfunction

  function automatic tree_answer_t answer_item(logic [MODE_W-1:0] mode,
                                               logic [FIELD_W-1:0] value);
    tree_answer_t          ans;
    logic [VALUE_BITS-1:0] key;
    bit                    got_child, got_par, got_ls, got_rs;
    int unsigned           slot;
    ans = '0;
    key = value[VALUE_BITS-1:0];
    got_child = 1'b0;
    got_par = 1'b0;
    got_ls = 1'b0;
    got_rs = 1'b0;
    case (mode)
      MODE_CLEAR: begin
        foreach (tree_mirror[i]) tree_mirror[i] = '0;
        mirror_fill = 0;
      end
      MODE_LOAD: begin
        if (mirror_fill >= TREE_SLOTS) begin
          ans.status = STATUS_FULL;
        end else begin
          slot = mirror_fill;
          tree_mirror[slot] = key;
          if (slot != 0 && key != '0 && tree_mirror[(slot + 1) / 2 - 1] == '0)
            ans.status = STATUS_ORPHAN;
          mirror_fill++;
        end
      end
      MODE_QUERY: begin
        if (tree_mirror[0] != '0) begin
          for (int i = 0; i < TREE_SLOTS; i++) begin
            if (tree_mirror[i] == key) begin
              if (!got_child) begin
                got_child = 1'b1;
                ans.lchild = mirror_at(2 * i + 1);
                ans.rchild = mirror_at(2 * i + 2);
              end
              if (i >= 1) begin
                if (!got_par) begin
                  got_par = 1'b1;
                  ans.parent = mirror_at((i + 1) / 2 - 1);
                end
                if (i % 2 == 0) begin
                  if (!got_ls) begin
                    got_ls = 1'b1;
                    ans.lsib = mirror_at(i - 1);
                  end
                end else if (!got_rs) begin
                  got_rs = 1'b1;
                  ans.rsib = mirror_at(i + 1);
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic string answer_text(tree_answer_t a);
    return $sformatf("status=%0d parent=%h lchild=%h rchild=%h lsib=%h rsib=%h",
                     a.status, a.parent, a.lchild, a.rchild, a.lsib, a.rsib);
  endfunction

  function automatic int unsigned idle_pct(bit sender);
    int unsigned phase;
    phase = (op_total == 0) ? 0 : accepted_ops * 3 / op_total;
    if (phase == 0) return sender ? 21 : 75;
    if (phase == 1) return sender ? 75 : 21;
    return 0;
  endfunction

  task automatic add_op(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] value, bit drain_first);
    tree_op_t op;
    op.mode = mode;
    op.value = value;
    op.drain_first = drain_first;
    op_queue.push_back(op);
    if (mode == MODE_CLEAR) begin
      foreach (plan_store[i]) plan_store[i] = '0;
      plan_fill = 0;
    end else if (mode == MODE_LOAD && plan_fill < TREE_SLOTS) begin
      plan_store[plan_fill] = value;
      plan_fill++;
    end
  endtask

  // mostly well-formed trees, some orphans
  function automatic logic [FIELD_W-1:0] load_value();
    bit          parent_empty;
    int unsigned r;
    parent_empty = plan_fill > 0 && plan_fill < TREE_SLOTS &&
                   plan_store[(plan_fill + 1) / 2 - 1] == '0;
    r = $urandom_range(99);
    if (parent_empty ? (r < 85) : (r < 15)) return '0;
    if (r % 2 == 1) return FIELD_W'($urandom_range(1, 6));
    return FIELD_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [FIELD_W-1:0] query_value();
    int unsigned r, filled, slot;
    r = $urandom_range(99);
    filled = (plan_fill < TREE_SLOTS) ? plan_fill : TREE_SLOTS;
    if (r < 60 && filled > 0) begin
      if (r < 25 && filled > 20) slot = $urandom_range(filled - 20, filled - 1);
      else slot = $urandom_range(filled - 1);
      return plan_store[slot];
    end
    if (r < 75) return '0;
    if (r < 85) return FIELD_W'($urandom_range(1, 6));
    return FIELD_W'($urandom);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.mode <= MODE_CLEAR;
      in_bus.node_value <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        answer_queue.push_back(answer_item(in_bus.mode, in_bus.node_value));
        void'(op_queue.pop_front());
        accepted_ops++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (op_queue.size() > 0 && !(op_queue[0].drain_first && answer_queue.size() > 0) &&
            $urandom_range(99) >= idle_pct(1'b1)) begin
          in_bus.valid <= 1'b1;
          in_bus.mode <= op_queue[0].mode;
          in_bus.node_value <= op_queue[0].value;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    tree_answer_t got, want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.status = out_bus.status;
        got.parent = out_bus.parent_value;
        got.lchild = out_bus.left_child_value;
        got.rchild = out_bus.right_child_value;
        got.lsib = out_bus.left_sibling_value;
        got.rsib = out_bus.right_sibling_value;
        if (answer_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %s", $time, answer_text(got));
          error_count++;
        end else begin
          want = answer_queue.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %s, actual %s", $time,
                     answer_text(want), answer_text(got));
            error_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_array_binary_tree_query: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned n_loads, n_queries;
    bit          first_seq, drain;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_CLEAR;
    in_bus.node_value = '0;
    out_bus.ready = 1'b0;
    rst_ni = 1'b0;

    // empty root, unused mode
    add_op(MODE_QUERY, 16'd5, 1'b0);
    add_op(MODE_SPARE, 16'hFFFF, 1'b0);
    // small tree with an orphan below an empty node
    add_op(MODE_LOAD, 16'd10, 1'b0);
    add_op(MODE_LOAD, 16'd0, 1'b0);
    add_op(MODE_LOAD, 16'd20, 1'b0);
    add_op(MODE_LOAD, 16'd7, 1'b0);
    add_op(MODE_LOAD, 16'd0, 1'b0);
    add_op(MODE_LOAD, 16'd20, 1'b0);
    add_op(MODE_LOAD, 16'd30, 1'b0);
    add_op(MODE_LOAD, 16'hFFFF, 1'b0);
    add_op(MODE_QUERY, 16'd20, 1'b0);
    add_op(MODE_QUERY, 16'd0, 1'b0);
    add_op(MODE_QUERY, 16'd10, 1'b0);
    add_op(MODE_QUERY, 16'hFFFF, 1'b0);
    add_op(MODE_QUERY, 16'd7, 1'b0);
    add_op(MODE_QUERY, 16'h1234, 1'b0);
    add_op(MODE_QUERY, 16'd30, 1'b0);
    add_op(MODE_SPARE, 16'h0000, 1'b1);
    add_op(MODE_CLEAR, 16'hFFFF, 1'b0);
    add_op(MODE_QUERY, 16'd10, 1'b0);
    // zero root, then a search for zero
    add_op(MODE_LOAD, 16'd0, 1'b0);
    add_op(MODE_LOAD, 16'd5, 1'b0);
    add_op(MODE_QUERY, 16'd0, 1'b0);

    first_seq = 1'b1;
    while (op_queue.size() < ITEM_GOAL) begin
      drain = first_seq || ($urandom_range(7) == 0);
      if (first_seq || $urandom_range(7) == 0) n_loads = TREE_SLOTS + $urandom_range(3);
      else n_loads = $urandom_range(1, 40);
      if ($urandom_range(9) != 0) add_op(MODE_CLEAR, FIELD_W'($urandom), drain);
      else add_op(MODE_SPARE, FIELD_W'($urandom), drain);
      for (int k = 0; k < n_loads; k++) begin
        if ($urandom_range(29) == 0) add_op(MODE_SPARE, FIELD_W'($urandom), 1'b0);
        add_op(MODE_LOAD, load_value(), 1'b0);
      end
      n_queries = (n_loads >= TREE_SLOTS) ? $urandom_range(8, 14) : $urandom_range(3, 10);
      for (int k = 0; k < n_queries; k++) begin
        add_op(MODE_QUERY, query_value(), 1'b0);
      end
      first_seq = 1'b0;
    end
    op_total = op_queue.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (op_queue.size() > 0 || answer_queue.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_array_binary_tree_query: done, clean");
    end else begin
      $display("tb_array_binary_tree_query: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/abtq_pkg.sv
rtl/abtq_in_if.sv
rtl/abtq_out_if.sv
rtl/abtq_ram.sv
rtl/abtq_match.sv
rtl/array_binary_tree_query.sv
tb/tb_array_binary_tree_query.sv
